[hdl/sptc_pkg.sv]
package sptc_pkg;

    // Event codes carried in the kind field
    localparam logic [2:0] KIND_CONNECT    = 3'd0;
    localparam logic [2:0] KIND_DISCONNECT = 3'd1;
    localparam logic [2:0] KIND_FRAME_FROM = 3'd2;
    localparam logic [2:0] KIND_FRAME_TO   = 3'd3;
    localparam logic [2:0] KIND_CLEAR_CNT  = 3'd4;
    localparam logic [2:0] KIND_READ       = 3'd5;

    // Frames with fewer captured bytes than this are not counted
    localparam logic [15:0] MIN_CAPTURED = 16'd14;

    // Width that holds any slot number up to the largest table
    localparam int SLOT_EXT_W = 7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_RESOLVE,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic [47:0] mac;
        logic [15:0] frame_length;
        logic [15:0] captured_length;
        logic [3:0]  slot_index;
    } t_evt;

    typedef struct packed {
        logic        hit;
        logic [3:0]  slot;
        logic [47:0] entry_mac;
        logic        entry_active;
        logic        entry_connected;
        logic [63:0] entry_bytes_sent;
        logic [63:0] entry_bytes_received;
        logic [31:0] entry_packets_sent;
        logic [31:0] entry_packets_received;
    } t_res;

    // One row of the counter memory
    typedef struct packed {
        logic [63:0] bytes_tx;
        logic [63:0] bytes_rcvd;
        logic [31:0] pkts_sent;
        logic [31:0] pkts_rcvd;
    } t_cnt;

endpackage

[hdl/sptc_if.sv]
interface sptc_evt_if;
    logic              valid;
    logic              ready;
    sptc_pkg::t_evt    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sptc_res_if;
    logic              valid;
    logic              ready;
    sptc_pkg::t_res    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/sptc_cnt_ram.sv]
module sptc_cnt_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_addr,
    input  sptc_pkg::t_cnt    i_wdata,
    output sptc_pkg::t_cnt    o_rdata
);

    sptc_pkg::t_cnt r_mem [DEPTH];
    sptc_pkg::t_cnt r_rdata;

    // Write one row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // Read one row, data valid the next cycle and held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/per_station_traffic_counter_table_unit.sv]
// Channel   Dir  Type          Content
// i_evt     in   sptc_evt_if   one event: kind, mac, lengths, slot index
// o_res     out   sptc_res_if  one result per event: hit, slot, entry contents
//
// Each event passes four steps: capture, address compare against all slots,
// slot resolve with memory read, counter update with result load.
// The counter memory read-modify-write spans the resolve and update steps.
// Reset clears all slot state at once; counters of cleared slots read as zero.
// A result waiting on o_res does not block the next event until its own
// update step; the unit then holds until the output register frees.
module per_station_traffic_counter_table_unit #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sptc_evt_if.sink        i_evt,
    sptc_res_if.source      o_res
);

    localparam int SW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int XW = sptc_pkg::SLOT_EXT_W;

    sptc_pkg::t_state r_state, n_state;

    // Event registers
    logic [2:0]  r_kind;
    logic [47:0] r_mac;
    logic [15:0] r_flen;
    logic        r_long;
    logic [3:0]  r_idx;

    // Slot state held in flops
    logic [47:0]              r_addr [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_active;
    logic [TABLE_ENTRIES-1:0] r_conn;
    logic [TABLE_ENTRIES-1:0] r_cvalid;

    // Compare results
    logic [TABLE_ENTRIES-1:0] r_match, r_free, r_stale;
    logic [TABLE_ENTRIES-1:0] cmp_vec;

    // Resolved slot
    logic          r_hit;
    logic [SW-1:0] r_slot;

    // Output register
    logic           r_out_valid;
    sptc_pkg::t_res r_out;

    logic           ld_out;
    logic           accept;

    logic           mt_hit, fr_hit, st_hit;
    logic [SW-1:0]  mt_slot, fr_slot, st_slot;
    logic           res_hit, do_claim, do_conn_set, do_conn_clr;
    logic [SW-1:0]  res_slot;
    logic [XW-1:0]  idx_ext, slot_ext;
    logic [SW-1:0]  idx_slot;
    logic           idx_in_range;
    logic           is_frame;

    logic           ram_rd, ram_wr;
    logic [SW-1:0]  ram_addr;
    sptc_pkg::t_cnt ram_q, cnt_cur, cnt_new;
    sptc_pkg::t_res res_d;

    assign accept   = i_evt.valid && i_evt.ready;
    assign is_frame = (r_kind == sptc_pkg::KIND_FRAME_FROM) ||
                      (r_kind == sptc_pkg::KIND_FRAME_TO);
    assign idx_ext      = {3'b000, r_idx};
    assign idx_slot     = idx_ext[SW-1:0];
    assign idx_in_range = idx_ext < XW'(TABLE_ENTRIES);
    assign slot_ext     = XW'(r_slot);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sptc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and step controls
    always_comb begin
        n_state     = r_state;
        i_evt.ready = 1'b0;
        ld_out      = 1'b0;
        case (r_state)
            sptc_pkg::S_IDLE: begin
                i_evt.ready = i_rst_n;
                if (i_evt.valid) begin
                    n_state = sptc_pkg::S_MATCH;
                end
            end
            sptc_pkg::S_MATCH: begin
                n_state = sptc_pkg::S_RESOLVE;
            end
            sptc_pkg::S_RESOLVE: begin
                n_state = sptc_pkg::S_UPDATE;
            end
            sptc_pkg::S_UPDATE: begin
                if (!r_out_valid || o_res.ready) begin
                    ld_out  = 1'b1;
                    n_state = sptc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sptc_pkg::S_IDLE;
            end
        endcase
    end

    // Capture the event
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_evt.data.kind;
            r_mac  <= i_evt.data.mac;
            r_flen <= i_evt.data.frame_length;
            r_long <= i_evt.data.captured_length >= sptc_pkg::MIN_CAPTURED;
            r_idx  <= i_evt.data.slot_index;
        end
    end

    // Compare the address against every active slot
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            cmp_vec[i] = r_active[i] && (r_addr[i] == r_mac);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sptc_pkg::S_MATCH) begin
            r_match <= cmp_vec;
            r_free  <= ~r_active;
            r_stale <= r_active & ~r_conn;
        end
    end

    // Find the lowest set bit of each candidate vector
    always_comb begin
        mt_hit  = 1'b0;
        fr_hit  = 1'b0;
        st_hit  = 1'b0;
        mt_slot = '0;
        fr_slot = '0;
        st_slot = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                mt_hit  = 1'b1;
                mt_slot = SW'(i);
            end
            if (r_free[i]) begin
                fr_hit  = 1'b1;
                fr_slot = SW'(i);
            end
            if (r_stale[i]) begin
                st_hit  = 1'b1;
                st_slot = SW'(i);
            end
        end
    end

    // Decide the slot and the change to slot state
    always_comb begin
        res_hit     = 1'b0;
        res_slot    = '0;
        do_claim    = 1'b0;
        do_conn_set = 1'b0;
        do_conn_clr = 1'b0;
        case (r_kind)
            sptc_pkg::KIND_CONNECT: begin
                if (mt_hit) begin
                    res_hit     = 1'b1;
                    res_slot    = mt_slot;
                    do_conn_set = 1'b1;
                end else if (fr_hit) begin
                    res_hit  = 1'b1;
                    res_slot = fr_slot;
                    do_claim = 1'b1;
                end else if (st_hit) begin
                    res_hit  = 1'b1;
                    res_slot = st_slot;
                    do_claim = 1'b1;
                end
            end
            sptc_pkg::KIND_DISCONNECT: begin
                if (mt_hit) begin
                    res_hit     = 1'b1;
                    res_slot    = mt_slot;
                    do_conn_clr = 1'b1;
                end
            end
            sptc_pkg::KIND_FRAME_FROM, sptc_pkg::KIND_FRAME_TO: begin
                if (r_long && mt_hit) begin
                    res_hit  = 1'b1;
                    res_slot = mt_slot;
                end
            end
            sptc_pkg::KIND_READ: begin
                res_slot = idx_slot;
            end
            default: begin
                res_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sptc_pkg::S_RESOLVE) begin
            r_hit  <= res_hit;
            r_slot <= res_slot;
        end
    end

    // Update slot state flops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_conn   <= '0;
            r_cvalid <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_addr[i] <= '0;
            end
        end else begin
            if (r_state == sptc_pkg::S_RESOLVE) begin
                if (do_claim) begin
                    r_addr[res_slot]   <= r_mac;
                    r_active[res_slot] <= 1'b1;
                    r_conn[res_slot]   <= 1'b1;
                    r_cvalid[res_slot] <= 1'b0;
                end
                if (do_conn_set) begin
                    r_conn[res_slot] <= 1'b1;
                end
                if (do_conn_clr) begin
                    r_conn[res_slot] <= 1'b0;
                end
                if (r_kind == sptc_pkg::KIND_CLEAR_CNT) begin
                    r_cvalid <= r_cvalid & ~r_active;
                end
            end
            if (ram_wr) begin
                r_cvalid[r_slot] <= 1'b1;
            end
        end
    end

    // Counter memory: read on resolve, write back on update
    assign ram_rd   = (r_state == sptc_pkg::S_RESOLVE);
    assign ram_wr   = ld_out && is_frame && r_hit;
    assign ram_addr = ram_rd ? res_slot : r_slot;

    sptc_cnt_ram #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (SW)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_rd_en (ram_rd),
        .i_wr_en (ram_wr),
        .i_addr  (ram_addr),
        .i_wdata (cnt_new),
        .o_rdata (ram_q)
    );

    // Treat cleared rows as zero and add the frame
    always_comb begin
        cnt_cur = r_cvalid[r_slot] ? ram_q : '0;
        cnt_new = cnt_cur;
        if (r_kind == sptc_pkg::KIND_FRAME_FROM) begin
            cnt_new.bytes_rcvd = cnt_cur.bytes_rcvd + 64'(r_flen);
            cnt_new.pkts_rcvd  = cnt_cur.pkts_rcvd + 32'd1;
        end else begin
            cnt_new.bytes_tx  = cnt_cur.bytes_tx + 64'(r_flen);
            cnt_new.pkts_sent = cnt_cur.pkts_sent + 32'd1;
        end
    end

    // Build the result
    always_comb begin
        res_d = '0;
        if (r_kind == sptc_pkg::KIND_READ) begin
            res_d.slot = r_idx;
            if (idx_in_range) begin
                res_d.hit                    = 1'b1;
                res_d.entry_mac              = r_addr[r_slot];
                res_d.entry_active           = r_active[r_slot];
                res_d.entry_connected        = r_conn[r_slot];
                res_d.entry_bytes_sent       = cnt_cur.bytes_tx;
                res_d.entry_bytes_received   = cnt_cur.bytes_rcvd;
                res_d.entry_packets_sent     = cnt_cur.pkts_sent;
                res_d.entry_packets_received = cnt_cur.pkts_rcvd;
            end
        end else if (r_hit) begin
            res_d.hit  = 1'b1;
            res_d.slot = slot_ext[3:0];
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out <= res_d;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

`ifndef SYNTH
    a_accept_to_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == sptc_pkg::S_MATCH))
        else $error("accepted transaction did not start a compare");

    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sptc_pkg::S_RESOLVE) |-> $onehot0(r_match))
        else $error("station address matches more than one slot");

    a_conn_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_conn & ~r_active) == '0)
        else $error("connected mark on an inactive slot");

    a_active_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((~r_active & $past(r_active)) == '0))
        else $error("active slot was released");

    a_write_on_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr |-> ((r_state == sptc_pkg::S_UPDATE) && r_long &&
                    ((r_kind == sptc_pkg::KIND_FRAME_FROM) ||
                     (r_kind == sptc_pkg::KIND_FRAME_TO))))
        else $error("counter write outside a counted frame");
`endif

endmodule
